// ===== hdl/bsd_pkg.sv =====
package bsd_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd256;
   localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd256;
   localparam logic [5:0]  BLOCK_SIZE_RESET   = 6'd16;

   localparam logic [15:0] STD_DEV_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUB,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/bsd_fifo.sv =====
module bsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       empty,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

// ===== hdl/bsd_front.sv =====
module bsd_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_BLOCK  = 32,
   localparam int WCW   = $clog2(MAX_WIDTH + 1),
   localparam int HCW   = $clog2(MAX_HEIGHT + 1),
   localparam int BW    = $clog2(MAX_BLOCK + 1),
   localparam int SUM_W = 8 + 2 * $clog2(MAX_BLOCK),
   localparam int SQS_W = 16 + 2 * $clog2(MAX_BLOCK)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic             accept,
   input  logic [7:0]       pixel,
   input  logic [WCW-1:0]   w_lim,
   input  logic [HCW-1:0]   h_lim,
   input  logic [BW-1:0]    b_lim,
   output logic             blk_push,
   output logic [SUM_W-1:0] blk_sum,
   output logic [SQS_W-1:0] blk_sq,
   output logic [HCW-1:0]   blk_row,
   output logic [WCW-1:0]   blk_col,
   output logic             blk_last
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [WCW-1:0] col_ff, col_in, tcol_ff, tcol_in;
   logic [HCW-1:0] row_ff, row_in, trow_ff, trow_in;
   logic [BW-1:0]  cib_ff, cib_in, rib_ff, rib_in;

   logic [SUM_W-1:0] seg_sum_ff, seg_sum_in;
   logic [SQS_W-1:0] seg_sq_ff, seg_sq_in;
   logic [15:0]      px_sq;

   logic end_col, end_row, row_last, frame_last, block_done;

   // Second stage: merge a finished row segment into the band entry
   logic             s1_valid_ff;
   logic             s1_first_ff, s1_end_row_ff, s1_last_ff, s1_fwd_ff;
   logic [CW-1:0]    s1_idx_ff;
   logic [SUM_W-1:0] s1_sum_ff, rd_sum_ff, wr_sum_ff, tot_sum;
   logic [SQS_W-1:0] s1_sq_ff, rd_sq_ff, wr_sq_ff, tot_sq;
   logic [HCW-1:0]   s1_row_ff;
   logic [WCW-1:0]   s1_col_ff;
   logic [CW-1:0]    idx;

   logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
   logic [SQS_W-1:0] sq_mem  [MAX_WIDTH];

   assign px_sq = 16'(pixel) * 16'(pixel);
   assign idx   = tcol_ff[CW-1:0];

   assign end_col    = (cib_ff + BW'(1) == b_lim) || (col_ff + WCW'(1) == w_lim);
   assign row_last   = (col_ff + WCW'(1) == w_lim);
   assign end_row    = (rib_ff + BW'(1) == b_lim) || (row_ff + HCW'(1) == h_lim);
   assign frame_last = row_last && (row_ff + HCW'(1) == h_lim);
   assign block_done = end_col && end_row;

   always_comb begin
      if (cib_ff == '0) begin
         seg_sum_in = SUM_W'(pixel);
         seg_sq_in  = SQS_W'(px_sq);
      end else begin
         seg_sum_in = seg_sum_ff + SUM_W'(pixel);
         seg_sq_in  = seg_sq_ff + SQS_W'(px_sq);
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      if (row_last) begin
         col_in  = '0;
         cib_in  = '0;
         tcol_in = '0;
         if (row_ff + HCW'(1) == h_lim) begin
            row_in  = '0;
            rib_in  = '0;
            trow_in = '0;
         end else begin
            row_in = row_ff + HCW'(1);
            if (rib_ff + BW'(1) == b_lim) begin
               rib_in  = '0;
               trow_in = trow_ff + HCW'(1);
            end else begin
               rib_in = rib_ff + BW'(1);
            end
         end
      end else begin
         col_in = col_ff + WCW'(1);
         if (cib_ff + BW'(1) == b_lim) begin
            cib_in  = '0;
            tcol_in = tcol_ff + WCW'(1);
         end else begin
            cib_in = cib_ff + BW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cib_ff  <= '0;
         rib_ff  <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cib_ff  <= cib_in;
         rib_ff  <= rib_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && end_col;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_sum_ff <= seg_sum_in;
         seg_sq_ff  <= seg_sq_in;
      end
      if (accept && end_col) begin
         s1_sum_ff     <= seg_sum_in;
         s1_sq_ff      <= seg_sq_in;
         s1_idx_ff     <= idx;
         s1_first_ff   <= (rib_ff == '0);
         s1_end_row_ff <= block_done;
         s1_row_ff     <= trow_ff;
         s1_col_ff     <= tcol_ff;
         s1_last_ff    <= frame_last;
         // Entry being written this edge: take the merged value instead of the stale read
         s1_fwd_ff     <= s1_valid_ff && (s1_idx_ff == idx);
      end
      if (s1_valid_ff) begin
         wr_sum_ff <= tot_sum;
         wr_sq_ff  <= tot_sq;
      end
   end

   always_comb begin
      if (s1_first_ff) begin
         tot_sum = s1_sum_ff;
         tot_sq  = s1_sq_ff;
      end else if (s1_fwd_ff) begin
         tot_sum = wr_sum_ff + s1_sum_ff;
         tot_sq  = wr_sq_ff + s1_sq_ff;
      end else begin
         tot_sum = rd_sum_ff + s1_sum_ff;
         tot_sq  = rd_sq_ff + s1_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && end_col) begin
         rd_sum_ff <= sum_mem[idx];
         rd_sq_ff  <= sq_mem[idx];
      end
      if (s1_valid_ff) begin
         sum_mem[s1_idx_ff] <= tot_sum;
         sq_mem[s1_idx_ff]  <= tot_sq;
      end
   end

   assign blk_push = s1_valid_ff && s1_end_row_ff;
   assign blk_sum  = tot_sum;
   assign blk_sq   = tot_sq;
   assign blk_row  = s1_row_ff;
   assign blk_col  = s1_col_ff;
   assign blk_last = s1_last_ff;

endmodule

// ===== hdl/bsd_back.sv =====
module bsd_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_BLOCK  = 32,
   localparam int WCW   = $clog2(MAX_WIDTH + 1),
   localparam int HCW   = $clog2(MAX_HEIGHT + 1),
   localparam int BW    = $clog2(MAX_BLOCK + 1),
   localparam int NW    = 2 * BW,
   localparam int SUM_W = 8 + 2 * $clog2(MAX_BLOCK),
   localparam int SQS_W = 16 + 2 * $clog2(MAX_BLOCK)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  logic [SUM_W-1:0] q_sum,
   input  logic [SQS_W-1:0] q_sq,
   input  logic [HCW-1:0]   q_row,
   input  logic [WCW-1:0]   q_col,
   input  logic             q_last,
   input  logic [NW-1:0]    n_blk,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [11:0]      rsp_block_row,
   output logic [9:0]       rsp_block_col,
   output logic [15:0]      rsp_std_dev,
   output logic             rsp_last_block
);

   localparam int NQ_W = NW + SQS_W;
   localparam int SS_W = 2 * SUM_W;
   localparam int DV_W = NQ_W + 16;
   localparam int DS_W = 2 * NW;
   localparam int RT_W = DV_W / 2;
   localparam int STW  = $clog2(DV_W);

   bsd_pkg::state_type st_ff, st_in;

   logic [SUM_W-1:0] s_ff;
   logic [SQS_W-1:0] q_ff;
   logic [HCW-1:0]   row_ff;
   logic [WCW-1:0]   col_ff;
   logic             last_ff;
   logic [NW-1:0]    n_ff;
   logic [NQ_W-1:0]  nq_ff;
   logic [SS_W-1:0]  ss_ff;
   logic [DS_W-1:0]  den_ff;
   logic [DV_W-1:0]  quo_ff;
   logic [DS_W-1:0]  rem_ff;
   logic [STW-1:0]   step_ff;
   logic [RT_W-1:0]  sr_ff;
   logic [RT_W+1:0]  srem_ff;

   logic [DV_W-1:0]  diff;
   logic [DS_W:0]    rem_sh;
   logic             div_ge;
   logic [RT_W+3:0]  srem_sh, trial;
   logic             sq_ge;
   logic             div_end, sqrt_end, out_load;
   logic [15:0]      sd_sat;

   logic             rsp_valid_ff;
   logic [11:0]      out_row_ff;
   logic [9:0]       out_col_ff;
   logic [15:0]      out_sd_ff;
   logic             out_last_ff;

   assign div_end  = (step_ff == STW'(DV_W - 1));
   assign sqrt_end = (step_ff == STW'(RT_W - 1));

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         bsd_pkg::ST_IDLE: if (!q_empty) st_in = bsd_pkg::ST_MUL;
         bsd_pkg::ST_MUL:  st_in = bsd_pkg::ST_SUB;
         bsd_pkg::ST_SUB:  st_in = (n_ff > NW'(1)) ? bsd_pkg::ST_DIV : bsd_pkg::ST_DONE;
         bsd_pkg::ST_DIV:  if (div_end) st_in = bsd_pkg::ST_SQRT;
         bsd_pkg::ST_SQRT: if (sqrt_end) st_in = bsd_pkg::ST_DONE;
         bsd_pkg::ST_DONE: if (!rsp_valid_ff || rsp_pop) st_in = bsd_pkg::ST_IDLE;
         default:          st_in = bsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (st_ff)
         bsd_pkg::ST_IDLE: q_pop = !q_empty;
         bsd_pkg::ST_DONE: out_load = !rsp_valid_ff || rsp_pop;
         default: begin
            q_pop    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bsd_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   assign diff = (DV_W'(nq_ff) > DV_W'(ss_ff)) ? DV_W'(nq_ff) - DV_W'(ss_ff) : '0;

   assign rem_sh = {rem_ff, quo_ff[DV_W-1]};
   assign div_ge = (rem_sh >= {1'b0, den_ff});

   assign srem_sh = {srem_ff, quo_ff[DV_W-1:DV_W-2]};
   assign trial   = (RT_W+4)'({sr_ff, 2'b01});
   assign sq_ge   = (srem_sh >= trial);

   assign sd_sat = (sr_ff > RT_W'(bsd_pkg::STD_DEV_MAX)) ? bsd_pkg::STD_DEV_MAX : sr_ff[15:0];

   always_ff @(posedge clock) begin
      unique case (st_ff)
         bsd_pkg::ST_IDLE: begin
            s_ff    <= q_sum;
            q_ff    <= q_sq;
            row_ff  <= q_row;
            col_ff  <= q_col;
            last_ff <= q_last;
            n_ff    <= n_blk;
         end
         bsd_pkg::ST_MUL: begin
            nq_ff  <= NQ_W'(n_ff) * NQ_W'(q_ff);
            ss_ff  <= SS_W'(s_ff) * SS_W'(s_ff);
            den_ff <= DS_W'(n_ff) * DS_W'(n_ff - NW'(1));
         end
         bsd_pkg::ST_SUB: begin
            quo_ff  <= diff << 16;
            rem_ff  <= '0;
            step_ff <= '0;
            sr_ff   <= '0;
            srem_ff <= '0;
         end
         bsd_pkg::ST_DIV: begin
            // One quotient bit per cycle, restoring
            rem_ff  <= div_ge ? DS_W'(rem_sh - {1'b0, den_ff}) : DS_W'(rem_sh);
            quo_ff  <= {quo_ff[DV_W-2:0], div_ge};
            step_ff <= div_end ? '0 : step_ff + STW'(1);
         end
         bsd_pkg::ST_SQRT: begin
            // One root bit per cycle, two radicand bits shifted in
            srem_ff <= sq_ge ? (RT_W+2)'(srem_sh - trial) : (RT_W+2)'(srem_sh);
            sr_ff   <= {sr_ff[RT_W-2:0], sq_ge};
            quo_ff  <= quo_ff << 2;
            step_ff <= step_ff + STW'(1);
         end
         bsd_pkg::ST_DONE: begin
            step_ff <= '0;
         end
         default: begin
            step_ff <= '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff  <= 12'(row_ff);
         out_col_ff  <= 10'(col_ff);
         out_sd_ff   <= sd_sat;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_block_row  = out_row_ff;
   assign rsp_block_col  = out_col_ff;
   assign rsp_std_dev    = out_sd_ff;
   assign rsp_last_block = out_last_ff;

endmodule

// ===== hdl/block_standard_deviation_core.sv =====
// Block standard deviation over a raster stream of 8-bit pixels. One pixel is taken per
// cycle while req_full is low. Band sums per tile column live in a RAM of MAX_WIDTH entries
// with one read port and one write port. An entry is written in the cycle after a row segment
// of a tile closes. Each finished block goes into a four-entry queue. A shared arithmetic
// unit works each block off in these steps:
//   - take the block,
//   - multiply,
//   - subtract,
//   - a restoring divider at one quotient bit per cycle,
//   - a square root at one bit per cycle,
//   - hand the result on.
// A block size of 1 skips the divider and the root. A result that waits on rsp_pop holds the
// unit. With the queue full, req_full holds off pixels until the unit drains a block. Over a
// frame, the input keeps one pixel per cycle when blocks finish on average no faster than the
// unit works them off. Results are 8.8 fixed point, truncated and saturated; a block size of
// 1 gives 0. Any write to registers 0..2 restarts the frame; write only while idle.
module block_standard_deviation_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_BLOCK  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [7:0]                      req_pixel,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [11:0]                     rsp_block_row,
   output logic [9:0]                      rsp_block_col,
   output logic [15:0]                     rsp_std_dev,
   output logic                            rsp_last_block,
   input  logic                            csr_we,
   input  logic [bsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WCW    = $clog2(MAX_WIDTH + 1);
   localparam int HCW    = $clog2(MAX_HEIGHT + 1);
   localparam int BW     = $clog2(MAX_BLOCK + 1);
   localparam int NW     = 2 * BW;
   localparam int SUM_W  = 8 + 2 * $clog2(MAX_BLOCK);
   localparam int SQS_W  = 16 + 2 * $clog2(MAX_BLOCK);
   localparam int QDEPTH = 4;
   localparam int QCW    = $clog2(QDEPTH + 1);
   localparam int QW     = SUM_W + SQS_W + HCW + WCW + 1;

   logic [10:0] img_w_ff;
   logic [12:0] img_h_ff;
   logic [5:0]  blk_ff;

   logic [WCW-1:0] w_lim;
   logic [HCW-1:0] h_lim;
   logic [BW-1:0]  b_lim;
   logic [NW-1:0]  n_blk;
   logic           restart, accept;

   logic             blk_push, blk_last;
   logic [SUM_W-1:0] blk_sum, q_sum;
   logic [SQS_W-1:0] blk_sq, q_sq;
   logic [HCW-1:0]   blk_row, q_row;
   logic [WCW-1:0]   blk_col, q_col;
   logic             q_last, q_empty, q_pop;
   logic [QW-1:0]    q_data;
   logic [QCW-1:0]   q_count;

   assign restart = csr_we && ((csr_index == bsd_pkg::CSR_IMAGE_WIDTH) ||
                               (csr_index == bsd_pkg::CSR_IMAGE_HEIGHT) ||
                               (csr_index == bsd_pkg::CSR_BLOCK_SIZE));

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= bsd_pkg::IMAGE_WIDTH_RESET;
         img_h_ff <= bsd_pkg::IMAGE_HEIGHT_RESET;
         blk_ff   <= bsd_pkg::BLOCK_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bsd_pkg::CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata[10:0];
            bsd_pkg::CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata[12:0];
            bsd_pkg::CSR_BLOCK_SIZE:   blk_ff   <= csr_wdata[5:0];
            default: begin
               img_w_ff <= img_w_ff;
            end
         endcase
      end
   end

   // Clamp registers into their usable ranges
   always_comb begin
      if (img_w_ff == '0) begin
         w_lim = WCW'(1);
      end else if (32'(img_w_ff) > MAX_WIDTH) begin
         w_lim = WCW'(MAX_WIDTH);
      end else begin
         w_lim = WCW'(img_w_ff);
      end
      if (img_h_ff == '0) begin
         h_lim = HCW'(1);
      end else if (32'(img_h_ff) > MAX_HEIGHT) begin
         h_lim = HCW'(MAX_HEIGHT);
      end else begin
         h_lim = HCW'(img_h_ff);
      end
      if (blk_ff == '0) begin
         b_lim = BW'(1);
      end else if (32'(blk_ff) > MAX_BLOCK) begin
         b_lim = BW'(MAX_BLOCK);
      end else begin
         b_lim = BW'(blk_ff);
      end
   end

   assign n_blk = NW'(b_lim) * NW'(b_lim);

   // Leave room for the block in flight and one more
   assign req_full = (QCW'(q_count + QCW'(blk_push)) >= QCW'(QDEPTH));
   assign accept   = req_push && !req_full;

   bsd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .accept  (accept),
      .pixel   (req_pixel),
      .w_lim   (w_lim),
      .h_lim   (h_lim),
      .b_lim   (b_lim),
      .blk_push(blk_push),
      .blk_sum (blk_sum),
      .blk_sq  (blk_sq),
      .blk_row (blk_row),
      .blk_col (blk_col),
      .blk_last(blk_last)
   );

   bsd_fifo #(
      .WIDTH(QW),
      .DEPTH(QDEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (blk_push),
      .push_data({blk_sum, blk_sq, blk_row, blk_col, blk_last}),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_data (q_data),
      .count    (q_count)
   );

   assign {q_sum, q_sq, q_row, q_col, q_last} = q_data;

   bsd_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_sum         (q_sum),
      .q_sq          (q_sq),
      .q_row         (q_row),
      .q_col         (q_col),
      .q_last        (q_last),
      .n_blk         (n_blk),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_block_row (rsp_block_row),
      .rsp_block_col (rsp_block_col),
      .rsp_std_dev   (rsp_std_dev),
      .rsp_last_block(rsp_last_block)
   );

endmodule

// ===== dv/block_standard_deviation_checker.sv =====
module block_standard_deviation_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [7:0]                      req_pixel,
   input  logic                            req_full,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [11:0]                     rsp_block_row,
   input  logic [9:0]                      rsp_block_col,
   input  logic [15:0]                     rsp_std_dev,
   input  logic                            rsp_last_block,
   input  logic                            csr_we,
   input  logic [bsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              errors,
   output int                              pending
);

   localparam int WIDTH_LIMIT  = 1024;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int BLOCK_LIMIT  = 32;

   typedef struct packed {
      logic [11:0] block_row;
      logic [9:0]  block_col;
      logic [15:0] std_dev;
      logic        last_block;
   } tile_stat_type;

   tile_stat_type expected_stats[$];

   logic [10:0] width_reg;
   logic [12:0] height_reg;
   logic [5:0]  block_reg;
   int unsigned col_pos, row_pos, col_in_tile, row_in_tile, tile_col, tile_row;
   longint unsigned col_sum[WIDTH_LIMIT];
   longint unsigned col_sq_sum[WIDTH_LIMIT];

   assign pending = expected_stats.size();

   function automatic int unsigned bound(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
         trial = r | (64'd1 << k);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   function automatic logic [15:0] tile_deviation(longint unsigned n, longint unsigned s,
                                                  longint unsigned q);
      longint unsigned nq, ss, spread, r;
      if (n <= 1) return 16'd0;
      nq = n * q;
      ss = s * s;
      spread = (nq > ss) ? nq - ss : 0;
      r = int_root((spread << 16) / (n * (n - 1)));
      return (r > 65535) ? bsd_pkg::STD_DEV_MAX : r[15:0];
   endfunction

   task automatic restart_frame();
      col_pos = 0; row_pos = 0; col_in_tile = 0;
      row_in_tile = 0; tile_col = 0; tile_row = 0;
   endtask

   task automatic account_pixel(logic [7:0] pix);
      int unsigned w, h, b, slot;
      longint unsigned p;
      logic col_done, row_done, line_end;
      tile_stat_type stat;
      w = bound(width_reg, WIDTH_LIMIT);
      h = bound(height_reg, HEIGHT_LIMIT);
      b = bound(block_reg, BLOCK_LIMIT);
      p = pix;
      slot = (tile_col >= WIDTH_LIMIT) ? WIDTH_LIMIT - 1 : tile_col;
      if (row_in_tile == 0 && col_in_tile == 0) begin
         col_sum[slot] = p;
         col_sq_sum[slot] = p * p;
      end else begin
         col_sum[slot] += p;
         col_sq_sum[slot] += p * p;
      end
      line_end = (col_pos + 1 >= w);
      col_done = (col_in_tile + 1 >= b) || line_end;
      row_done = (row_in_tile + 1 >= b) || (row_pos + 1 >= h);
      if (col_done && row_done) begin
         stat.block_row = tile_row[11:0];
         stat.block_col = tile_col[9:0];
         stat.std_dev = tile_deviation(b * b, col_sum[slot], col_sq_sum[slot]);
         stat.last_block = line_end && (row_pos + 1 >= h);
         expected_stats.push_back(stat);
      end
      if (line_end) begin
         col_pos = 0; col_in_tile = 0; tile_col = 0;
         if (row_pos + 1 >= h) begin
            restart_frame();
         end else begin
            row_pos++;
            if (row_in_tile + 1 >= b) begin
               row_in_tile = 0;
               tile_row++;
            end else begin
               row_in_tile++;
            end
         end
      end else begin
         col_pos++;
         if (col_in_tile + 1 >= b) begin
            col_in_tile = 0;
            tile_col++;
         end else begin
            col_in_tile++;
         end
      end
   endtask

   task automatic compare_stat();
      tile_stat_type want;
      if (expected_stats.size() == 0) begin
         $display("%0t: unexpected transfer row=%0d col=%0d std_dev=%0d last=%0d", $time,
                  rsp_block_row, rsp_block_col, rsp_std_dev, rsp_last_block);
         errors++;
         return;
      end
      want = expected_stats.pop_front();
      if (rsp_block_row !== want.block_row) begin
         $display("%0t: block_row expected %0d actual %0d", $time, want.block_row,
                  rsp_block_row);
         errors++;
      end
      if (rsp_block_col !== want.block_col) begin
         $display("%0t: block_col expected %0d actual %0d", $time, want.block_col,
                  rsp_block_col);
         errors++;
      end
      if (rsp_std_dev !== want.std_dev) begin
         $display("%0t: std_dev expected %0d actual %0d", $time, want.std_dev, rsp_std_dev);
         errors++;
      end
      if (rsp_last_block !== want.last_block) begin
         $display("%0t: last_block expected %0d actual %0d", $time, want.last_block,
                  rsp_last_block);
         errors++;
      end
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      if (reset) begin
         width_reg = bsd_pkg::IMAGE_WIDTH_RESET;
         height_reg = bsd_pkg::IMAGE_HEIGHT_RESET;
         block_reg = bsd_pkg::BLOCK_SIZE_RESET;
         restart_frame();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bsd_pkg::CSR_IMAGE_WIDTH: begin
                  width_reg = csr_wdata[10:0];
                  restart_frame();
               end
               bsd_pkg::CSR_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata[12:0];
                  restart_frame();
               end
               bsd_pkg::CSR_BLOCK_SIZE: begin
                  block_reg = csr_wdata[5:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_push && !req_full) account_pixel(req_pixel);
         if (rsp_pop && !rsp_empty) compare_stat();
      end
   end
endmodule

// ===== dv/block_standard_deviation_core_test.sv =====
module block_standard_deviation_core_test;

   localparam int DW = bsd_pkg::CSR_DATA_W;
   localparam logic [bsd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int TOTAL_PIXELS = 1700;

   logic                            clock;
   logic                            reset;
   logic                            req_push;
   logic [7:0]                      req_pixel;
   logic                            req_full;
   logic                            rsp_empty;
   logic                            rsp_pop;
   logic [11:0]                     rsp_block_row;
   logic [9:0]                      rsp_block_col;
   logic [15:0]                     rsp_std_dev;
   logic                            rsp_last_block;
   logic                            csr_we;
   logic [bsd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [DW-1:0]                   csr_wdata;
   int                              errors;
   int                              pending;
   int                              burst_left;
   int                              pixels_sent;
   int                              stall_mode;
   int                              stall_count;

   block_standard_deviation_core dut (.*);

   block_standard_deviation_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 4000000);
      $display("FAIL");
      $finish;
   end

   // Receiver: cycle through free flow, random stalls and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_mode <= 0;
         stall_count <= 0;
      end else begin
         if (stall_count >= 300) begin
            stall_mode <= $urandom_range(0, 2);
            stall_count <= 0;
         end else begin
            stall_count <= stall_count + 1;
         end
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Hold the sender and wait until every expected result has come.
   task automatic drain();
      req_push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [bsd_pkg::CSR_INDEX_W-1:0] idx, logic [DW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(int w, int h, int b);
      drain();
      write_reg(bsd_pkg::CSR_IMAGE_WIDTH, DW'(w));
      write_reg(bsd_pkg::CSR_IMAGE_HEIGHT, DW'(h));
      write_reg(bsd_pkg::CSR_BLOCK_SIZE, DW'(b));
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(logic [7:0] pix);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_push <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full);
      burst_left--;
      pixels_sent++;
   endtask

   function automatic logic [7:0] any_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int w, h, b, count;
      bit held_once;
      reset = 1'b1;
      req_push = 1'b0;
      req_pixel = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      burst_left = 0;
      pixels_sent = 0;
      held_once = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Partial edge blocks, extreme pixels.
      configure(3, 2, 2);
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
      send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd128);
      // Block size one.
      configure(4, 2, 1);
      for (int i = 0; i < 8; i++) send_pixel(i[0] ? 8'd255 : 8'd0);
      // Zero registers clamp up.
      configure(0, 0, 0);
      send_pixel(8'd77); send_pixel(8'd255);
      // An unused index changes nothing.
      drain();
      write_reg(CSR_UNUSED, DW'($urandom_range(0, 8191)));
      csr_we <= 1'b0;
      send_pixel(8'd3);
      // Tall frame, clamped height; only the top bands are visited.
      configure(1, 8191, 2);
      for (int i = 0; i < 40; i++) send_pixel(any_pixel());
      // Widest row, oversized block clamps down.
      configure(2047, 1, 63);
      for (int i = 0; i < 1024; i++) send_pixel(any_pixel());

      while (pixels_sent < TOTAL_PIXELS) begin
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 24);
         b = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         count = w * h;
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
         configure(w, h, b);
         for (int i = 0; i < count; i++) begin
            if (!held_once && i == count / 2 && pending != 0) begin
               drain();
               held_once = 1;
            end
            send_pixel(any_pixel());
         end
      end

      drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
